// ----- design/rthsb_pkg.sv -----
// Shared types and constants for the RGB to hue/saturation/brightness pixel core.
// No dependencies; every other design file refers to this package by scoped names.

package rthsb_pkg;

	// Field widths of the divider datapath.
	localparam int unsigned QUOT_W       = 8;
	localparam int unsigned HREM_W       = 19;
	localparam int unsigned HDIV_W       = 11;
	localparam int unsigned SREM_W       = 16;
	localparam int unsigned SDIV_W       = 8;
	localparam int unsigned FRONT_STAGES = 3;
	localparam int unsigned PIPE_STAGES  = FRONT_STAGES + QUOT_W;

	// Which channel holds the maximum; ties go red, then green.
	localparam logic [1:0] SEL_RED   = 2'd0;
	localparam logic [1:0] SEL_GREEN = 2'd1;
	localparam logic [1:0] SEL_BLUE  = 2'd2;

	typedef logic [HREM_W-1:0] hrem_t;
	typedef logic [HDIV_W-1:0] hdiv_t;
	typedef logic [SREM_W-1:0] srem_t;
	typedef logic [SDIV_W-1:0] sdiv_t;
	typedef logic [QUOT_W-1:0] quot_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_rgb_t;

	typedef struct packed {
		logic [7:0] hue;
		logic [7:0] saturation;
		logic [7:0] brightness;
	} pixel_hsb_t;

	// State of both restoring dividers as it moves down the pipeline.
	typedef struct packed {
		hrem_t      hrem;
		hdiv_t      hdiv;
		quot_t      hq;
		srem_t      srem;
		sdiv_t      sdiv;
		quot_t      sq;
		logic [7:0] bright;
	} rthsb_div_t;

endpackage

// ----- design/rthsb_front.sv -----
// Front end of the pixel core: max/min search, hue numerator, and the scaled
// dividends and divisors. Three pipeline stages; depends on rthsb_pkg.

module rthsb_front (
	input  logic                   clk,
	input  logic [2:0]             en,
	input  rthsb_pkg::pixel_rgb_t  pix,
	output rthsb_pkg::rthsb_div_t  div_s3
);

	logic       red_max;
	logic       green_max;
	logic [7:0] mx_c;
	logic [7:0] mn_c;
	logic [1:0] sel_c;

	logic [7:0] r_s1, g_s1, b_s1, mx_s1, d_s1;
	logic [1:0] sel_s1;

	logic [11:0] d12;
	logic [11:0] six_d;
	logic [11:0] num_c;

	logic [10:0] num_s2;
	logic [10:0] sixd_s2;
	logic [7:0]  d_s2;
	logic [7:0]  mx_s2;

	rthsb_pkg::hrem_t num_w;
	rthsb_pkg::srem_t d_w;
	rthsb_pkg::rthsb_div_t div_c;

	// Stage 1: find the largest and smallest channel.
	always_comb begin
		red_max   = (pix.red >= pix.green) && (pix.red >= pix.blue);
		green_max = (pix.green >= pix.blue);
		if (red_max) begin
			mx_c  = pix.red;
			sel_c = rthsb_pkg::SEL_RED;
		end else if (green_max) begin
			mx_c  = pix.green;
			sel_c = rthsb_pkg::SEL_GREEN;
		end else begin
			mx_c  = pix.blue;
			sel_c = rthsb_pkg::SEL_BLUE;
		end
		mn_c = (pix.red <= pix.green) ? pix.red : pix.green;
		if (pix.blue < mn_c) begin
			mn_c = pix.blue;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			r_s1   <= pix.red;
			g_s1   <= pix.green;
			b_s1   <= pix.blue;
			mx_s1  <= mx_c;
			d_s1   <= mx_c - mn_c;
			sel_s1 <= sel_c;
		end
	end

	// Stage 2: hue numerator for the sector picked by the largest channel.
	always_comb begin
		d12   = {4'b0, d_s1};
		six_d = (d12 << 2) + (d12 << 1);
		case (sel_s1)
			rthsb_pkg::SEL_RED: begin
				if (g_s1 >= b_s1) begin
					num_c = {4'b0, g_s1} - {4'b0, b_s1};
				end else begin
					num_c = six_d - ({4'b0, b_s1} - {4'b0, g_s1});
				end
			end
			rthsb_pkg::SEL_GREEN: begin
				num_c = (d12 << 1) + {4'b0, b_s1} - {4'b0, r_s1};
			end
			rthsb_pkg::SEL_BLUE: begin
				num_c = (d12 << 2) + {4'b0, r_s1} - {4'b0, g_s1};
			end
			default: begin
				num_c = 12'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			num_s2  <= num_c[10:0];
			sixd_s2 <= six_d[10:0];
			d_s2    <= d_s1;
			mx_s2   <= mx_s1;
		end
	end

	// Stage 3: multiply by 255 as x*256 - x. A zero divisor only occurs with a
	// zero dividend, so it is replaced by one to give a zero quotient.
	always_comb begin
		num_w       = rthsb_pkg::hrem_t'(num_s2);
		d_w         = rthsb_pkg::srem_t'(d_s2);
		div_c.hrem  = (num_w << 8) - num_w;
		div_c.hdiv  = (d_s2 == 8'd0) ? rthsb_pkg::hdiv_t'(1) : sixd_s2;
		div_c.hq    = '0;
		div_c.srem  = (d_w << 8) - d_w;
		div_c.sdiv  = (mx_s2 == 8'd0) ? rthsb_pkg::sdiv_t'(1) : mx_s2;
		div_c.sq    = '0;
		div_c.bright = mx_s2;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			div_s3 <= div_c;
		end
	end

endmodule

// ----- design/rthsb_div_stage.sv -----
// One stage of the two pipelined restoring dividers: settles one quotient bit
// of hue and one of saturation. Depends on rthsb_pkg.

module rthsb_div_stage #(
	parameter int unsigned Bit = 7
) (
	input  logic                  clk,
	input  logic                  en,
	input  rthsb_pkg::rthsb_div_t din,
	output rthsb_pkg::rthsb_div_t dout
);

	rthsb_pkg::hrem_t      hsh;
	rthsb_pkg::srem_t      ssh;
	rthsb_pkg::rthsb_div_t nxt;

	// Subtract the divisor shifted to this bit wherever it fits.
	always_comb begin
		hsh = rthsb_pkg::hrem_t'(din.hdiv) << Bit;
		ssh = rthsb_pkg::srem_t'(din.sdiv) << Bit;
		nxt = din;
		if (din.hrem >= hsh) begin
			nxt.hrem    = din.hrem - hsh;
			nxt.hq[Bit] = 1'b1;
		end
		if (din.srem >= ssh) begin
			nxt.srem    = din.srem - ssh;
			nxt.sq[Bit] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

endmodule

// ----- design/rgb_to_hsb_pixel_core.sv -----
// Top level of the RGB to hue/saturation/brightness pixel converter.
// Uses rthsb_pkg, rthsb_front and rthsb_div_stage.

// The core takes one 8-bit RGB pixel per clock and returns hue, saturation
// and brightness on a 0..255 scale, truncated. The pipeline has three front
// stages (max/min, hue numerator, scaling by 255) followed by eight divider
// stages, each producing one quotient bit of both the hue and the saturation
// divisions. The pipeline is stalled as a whole only when the output item is
// held by a low hsb_ready; otherwise one item enters and one leaves every
// cycle.

module rgb_to_hsb_pixel_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_ready,
	input  rthsb_pkg::pixel_rgb_t pix,
	output logic                  hsb_valid,
	input  logic                  hsb_ready,
	output rthsb_pkg::pixel_hsb_t hsb
);

	localparam int unsigned NStages = rthsb_pkg::PIPE_STAGES;
	localparam int unsigned QBits   = rthsb_pkg::QUOT_W;

	logic                  advance;
	logic [NStages-1:0]    valid_q;
	rthsb_pkg::rthsb_div_t div_data [0:QBits];

	// Whole-pipeline advance whenever the output register is free or drained.
	assign advance   = !valid_q[NStages-1] || hsb_ready;
	assign pix_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (advance) begin
			valid_q <= {valid_q[NStages-2:0], pix_valid};
		end
	end

	rthsb_front u_front (
		.clk    (clk),
		.en     ({3{advance}}),
		.pix    (pix),
		.div_s3 (div_data[0])
	);

	// Divider stages, most significant quotient bit first.
	for (genvar i = 0; i < QBits; i++) begin : g_div
		rthsb_div_stage #(
			.Bit (QBits - 1 - i)
		) u_stage (
			.clk  (clk),
			.en   (advance),
			.din  (div_data[i]),
			.dout (div_data[i+1])
		);
	end

	// The last divider stage is the output register.
	assign hsb_valid      = valid_q[NStages-1];
	assign hsb.hue        = div_data[QBits].hq;
	assign hsb.saturation = div_data[QBits].sq;
	assign hsb.brightness = div_data[QBits].bright;

endmodule

// ----- sim/tb_rgb_to_hsb_pixel_core.sv -----
// Self-checking testbench for rgb_to_hsb_pixel_core: directed and random pixels with idle
// and stall patterns on both sides, checked against a built-in hue/saturation predictor.
// Depends on rthsb_pkg and the rgb_to_hsb_pixel_core design files.

module tb_rgb_to_hsb_pixel_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_PIXELS = 1200;
	localparam int unsigned DRAIN_CYCLES  = 3 * rthsb_pkg::PIPE_STAGES;
	localparam int unsigned HOLD_CYCLES   = 150;
	localparam int unsigned HOLD_COUNT    = 2;

	typedef enum {READY_ALWAYS, READY_HALF, READY_MOSTLY, READY_TOGGLE} ready_mode_t;
	typedef enum {PIX_ANY, PIX_GREY, PIX_TIE, PIX_NEAR, PIX_EXTREME, PIX_ONE_ZERO} pixel_kind_t;

	// Holds the expected conversions of accepted pixels and checks each output item.
	class hsb_scoreboard;
		rthsb_pkg::pixel_hsb_t expected_hsb[$];
		rthsb_pkg::pixel_rgb_t pending_rgb[$];
		int unsigned           received;
		int unsigned           failures;

		// Exact integer hexcone conversion; ties for the maximum go red, then green.
		function rthsb_pkg::pixel_hsb_t hsb_of_rgb(rthsb_pkg::pixel_rgb_t p);
			logic [7:0]            mx;
			logic [7:0]            mn;
			logic [7:0]            d;
			logic [10:0]           d11;
			logic [10:0]           num;
			logic [15:0]           sat_scaled;
			logic [18:0]           hue_scaled;
			rthsb_pkg::pixel_hsb_t o;
			mx = p.red;
			if (p.green > mx) mx = p.green;
			if (p.blue > mx) mx = p.blue;
			mn = p.red;
			if (p.green < mn) mn = p.green;
			if (p.blue < mn) mn = p.blue;
			d   = mx - mn;
			d11 = {3'd0, d};
			o.brightness = mx;
			sat_scaled   = {8'd0, d} * 16'd255;
			o.saturation = (mx == 8'd0) ? 8'd0 : 8'(sat_scaled / {8'd0, mx});
			if (d == 8'd0) begin
				o.hue = 8'd0;
			end else begin
				if (p.red == mx) begin
					if (p.green >= p.blue) num = {3'd0, 8'(p.green - p.blue)};
					else num = 11'd6 * d11 - {3'd0, 8'(p.blue - p.green)};
				end else if (p.green == mx) begin
					num = 11'd2 * d11 + {3'd0, p.blue} - {3'd0, p.red};
				end else begin
					num = 11'd4 * d11 + {3'd0, p.red} - {3'd0, p.green};
				end
				hue_scaled = {8'd0, num} * 19'd255;
				o.hue      = 8'(hue_scaled / (19'd6 * {11'd0, d}));
			end
			return o;
		endfunction

		function void note_pixel(rthsb_pkg::pixel_rgb_t p);
			expected_hsb.push_back(hsb_of_rgb(p));
			pending_rgb.push_back(p);
		endfunction

		function void check_hsb(rthsb_pkg::pixel_hsb_t got);
			rthsb_pkg::pixel_hsb_t want;
			rthsb_pkg::pixel_rgb_t src;
			received++;
			if (expected_hsb.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%t hsb error: output item h%0d s%0d b%0d with no pixel pending",
						$realtime, got.hue, got.saturation, got.brightness);
				return;
			end
			want = expected_hsb.pop_front();
			src  = pending_rgb.pop_front();
			if (got.hue != want.hue || got.saturation != want.saturation ||
					got.brightness != want.brightness) begin
				failures++;
				if (failures <= 10)
					$display({"%t hsb error: rgb %0d,%0d,%0d expected h%0d s%0d b%0d,",
						" got h%0d s%0d b%0d"},
						$realtime, src.red, src.green, src.blue, want.hue, want.saturation,
						want.brightness, got.hue, got.saturation, got.brightness);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  pix_valid;
	logic                  pix_ready;
	rthsb_pkg::pixel_rgb_t pix;
	logic                  hsb_valid;
	logic                  hsb_ready;
	rthsb_pkg::pixel_hsb_t hsb;

	hsb_scoreboard board;
	int            burst_left;

	rgb_to_hsb_pixel_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.hsb_valid (hsb_valid),
		.hsb_ready (hsb_ready),
		.hsb       (hsb)
	);

	// Free-running 100 MHz clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Safety net against a hung handshake.
	initial begin
		#2_000_000;
		$display("rgb_to_hsb_pixel_core: mismatch");
		$finish;
	end

	// Offers one pixel and waits until it is taken; gaps fall between bursts.
	task automatic offer_pixel(input rthsb_pkg::pixel_rgb_t p);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				pix_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
				: $urandom_range(1, 40);
		end
		burst_left--;
		pix       <= p;
		pix_valid <= 1'b1;
		do @(posedge clk); while (!pix_ready);
		board.note_pixel(p);
	endtask

	// Random pixel biased toward greys, ties, narrow ranges and the channel extremes.
	function automatic rthsb_pkg::pixel_rgb_t random_pixel();
		pixel_kind_t           kind;
		rthsb_pkg::pixel_rgb_t p;
		logic [7:0]            hi;
		logic [7:0]            lo;
		int                    pick;
		int                    k;
		k    = $urandom_range(0, 9);
		kind = (k < 5) ? PIX_ANY : pixel_kind_t'(k - 4);
		p    = rthsb_pkg::pixel_rgb_t'(24'($urandom));
		case (kind)
			PIX_GREY: begin
				hi = 8'($urandom);
				p  = '{hi, hi, hi};
			end
			PIX_TIE: begin
				hi   = 8'($urandom_range(1, 255));
				lo   = 8'($urandom_range(0, hi));
				pick = $urandom_range(0, 2);
				if (pick == 0) p = '{hi, hi, lo};
				else if (pick == 1) p = '{hi, lo, hi};
				else p = '{lo, hi, hi};
			end
			PIX_NEAR: begin
				hi = 8'($urandom_range(0, 252));
				p  = '{hi + 8'($urandom_range(0, 3)), hi + 8'($urandom_range(0, 3)),
					hi + 8'($urandom_range(0, 3))};
			end
			PIX_EXTREME: begin
				if ($urandom_range(0, 2) == 0)
					p.red = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
				if ($urandom_range(0, 2) == 0)
					p.green = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
				if ($urandom_range(0, 2) == 0)
					p.blue = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
			end
			PIX_ONE_ZERO: begin
				pick = $urandom_range(0, 2);
				if (pick == 0) p.red = 8'd0;
				else if (pick == 1) p.green = 8'd0;
				else p.blue = 8'd0;
			end
			default: begin
			end
		endcase
		return p;
	endfunction

	// Output side: checks every item taken and drives the stall pattern, with long hold-offs.
	initial begin
		ready_mode_t mode;
		int          seg_left;
		int          hold_left;
		int          holds_done;
		int unsigned next_hold;
		hsb_ready <= 1'b0;
		seg_left   = 0;
		hold_left  = 0;
		holds_done = 0;
		next_hold  = 300;
		mode       = READY_ALWAYS;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hsb_valid && hsb_ready) board.check_hsb(hsb);
			if (hold_left > 0) begin
				hold_left--;
				hsb_ready <= 1'b0;
			end else if (holds_done < HOLD_COUNT && board.received >= next_hold) begin
				// Hold off long enough for the pipeline to fill and push back on the input.
				hold_left = HOLD_CYCLES - 1;
				holds_done++;
				next_hold += 500;
				hsb_ready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					mode     = ready_mode_t'($urandom_range(0, 3));
					seg_left = $urandom_range(10, 80);
				end
				seg_left--;
				case (mode)
					READY_ALWAYS: hsb_ready <= 1'b1;
					READY_HALF:   hsb_ready <= 1'($urandom_range(0, 1));
					READY_MOSTLY: hsb_ready <= ($urandom_range(0, 3) != 0);
					READY_TOGGLE: hsb_ready <= ~hsb_ready;
					default:      hsb_ready <= 1'b1;
				endcase
			end
		end
	end

	// Input side: reset, directed pixels, random pixels, then drain and report.
	initial begin
		rthsb_pkg::pixel_rgb_t directed_rgb[$];
		board      = new;
		burst_left = 0;
		arst_n    <= 1'b0;
		pix_valid <= 1'b0;
		pix       <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Black, white, grey, primaries, hue wrap-around, tie order and small ranges.
		directed_rgb = '{
			'{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, '{8'd128, 8'd128, 8'd128},
			'{8'd255, 8'd0, 8'd0}, '{8'd0, 8'd255, 8'd0}, '{8'd0, 8'd0, 8'd255},
			'{8'd255, 8'd0, 8'd1}, '{8'd255, 8'd255, 8'd0}, '{8'd0, 8'd255, 8'd255},
			'{8'd255, 8'd0, 8'd255}, '{8'd1, 8'd0, 8'd0}, '{8'd0, 8'd1, 8'd0},
			'{8'd0, 8'd0, 8'd1}, '{8'd255, 8'd254, 8'd253}, '{8'd1, 8'd1, 8'd0},
			'{8'd200, 8'd100, 8'd50}, '{8'd50, 8'd200, 8'd100}, '{8'd100, 8'd50, 8'd200},
			'{8'd255, 8'd255, 8'd254}, '{8'd254, 8'd255, 8'd255}, '{8'hAA, 8'h55, 8'hAA},
			'{8'h55, 8'hAA, 8'h55}, '{8'd1, 8'd255, 8'd0}
		};
		foreach (directed_rgb[i]) offer_pixel(directed_rgb[i]);

		repeat (RANDOM_PIXELS) offer_pixel(random_pixel());
		pix_valid <= 1'b0;

		// Let every expected item arrive, then watch for strays.
		while (board.expected_hsb.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.failures == 0) begin
			$display("rgb_to_hsb_pixel_core: match");
		end else begin
			$display("rgb_to_hsb_pixel_core: mismatch");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/rthsb_pkg.sv
design/rthsb_front.sv
design/rthsb_div_stage.sv
design/rgb_to_hsb_pixel_core.sv
sim/tb_rgb_to_hsb_pixel_core.sv
